// ===== rtl/core/slfe_pkg.sv =====
// ----------------------------------------------------------------------------
// slfe_pkg
// Types and constants shared by the sync/length frame extractor.
// ----------------------------------------------------------------------------
package slfe_pkg;

  // Sync pair and length limits
  localparam logic [7:0]  SYNC_FIRST    = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND   = 8'h5A;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
  localparam logic [15:0] MIN_LEN       = 16'd4;

  // Configuration register word index (paddr[2])
  localparam logic REG_MAX_FRAME_LENGTH = 1'b0;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SEEN_A5,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD
  } phase_t;

  // Event from the parser to the output sequencer
  typedef struct packed {
    logic       emit_hdr;   // header accepted: emit four header bytes
    logic       emit_byte;  // payload byte pass-through
    logic [7:0] data;       // payload byte, or length low byte for a header
    logic [7:0] len_hi;     // length high byte for a header
    logic       last;       // item ends the frame
  } parse_ev_t;

endpackage

// ===== rtl/core/slfe_in_if.sv =====
// ----------------------------------------------------------------------------
// slfe_in_if
// Received byte stream channel: valid/ready handshake with one byte.
// ----------------------------------------------------------------------------
interface slfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/slfe_out_if.sv =====
// ----------------------------------------------------------------------------
// slfe_out_if
// Extracted frame byte channel: valid/ready handshake with frame flags.
// ----------------------------------------------------------------------------
interface slfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       first_of_frame;
  logic       last_of_frame;

  modport source (output valid, output frame_byte, output first_of_frame,
                  output last_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input first_of_frame,
                  input last_of_frame, output ready);
endinterface

// ===== rtl/core/sync_length_frame_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_extractor_unit
// Output is registered: a result byte is valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle in hunt and payload while the output is not held; the
// output register sends the four header bytes in turn, so the input stalls while they are queued.
// Reset (rst, synchronous): parser hunts, output empty, max length 4096.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // streams
  slfe_in_if.sink            rx_stream,
  slfe_out_if.source         frame_stream
);

  logic [15:0]         max_len;
  logic                cfg_wr;
  logic                rx_acc;
  logic                pop;
  slfe_pkg::parse_ev_t ev;

  // Output register and pending header bytes
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_first;
  logic       out_last;
  logic [1:0] hdr_left;
  logic [7:0] hdr_lo;
  logic [7:0] hdr_hi;
  logic       hdr_last;

  logic [7:0] seq_byte;
  logic       seq_last;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == slfe_pkg::REG_MAX_FRAME_LENGTH) ? {16'd0, max_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= slfe_pkg::MAX_LEN_RESET;
    end else if (cfg_wr && paddr[2] == slfe_pkg::REG_MAX_FRAME_LENGTH) begin
      max_len <= pwdata[15:0];
    end
  end

  // Handshakes: take a byte when the output slot frees and no header is queued
  assign pop             = out_valid && frame_stream.ready;
  assign rx_stream.ready = (!out_valid || frame_stream.ready) && (hdr_left == 2'd0);
  assign rx_acc          = rx_stream.valid && rx_stream.ready;

  slfe_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx_acc),
    .rx_byte (rx_stream.rx_byte),
    .max_len (max_len),
    .ev      (ev)
  );

  // Next queued header byte
  always_comb begin
    case (hdr_left)
      2'd3: begin
        seq_byte = slfe_pkg::SYNC_SECOND;
        seq_last = 1'b0;
      end
      2'd2: begin
        seq_byte = hdr_lo;
        seq_last = 1'b0;
      end
      2'd1: begin
        seq_byte = hdr_hi;
        seq_last = hdr_last;
      end
      default: begin
        seq_byte = 8'd0;
        seq_last = 1'b0;
      end
    endcase
  end

  // Output control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_left  <= 2'd0;
    end else if (rx_acc && ev.emit_hdr) begin
      out_valid <= 1'b1;
      hdr_left  <= 2'd3;
    end else if (rx_acc && ev.emit_byte) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      if (hdr_left != 2'd0) begin
        hdr_left <= hdr_left - 2'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (rx_acc && ev.emit_hdr) begin
      out_byte  <= slfe_pkg::SYNC_FIRST;
      out_first <= 1'b1;
      out_last  <= 1'b0;
      hdr_lo    <= ev.data;
      hdr_hi    <= ev.len_hi;
      hdr_last  <= ev.last;
    end else if (rx_acc && ev.emit_byte) begin
      out_byte  <= ev.data;
      out_first <= 1'b0;
      out_last  <= ev.last;
    end else if (pop && hdr_left != 2'd0) begin
      out_byte  <= seq_byte;
      out_first <= 1'b0;
      out_last  <= seq_last;
    end
  end

  assign frame_stream.valid          = out_valid;
  assign frame_stream.frame_byte     = out_byte;
  assign frame_stream.first_of_frame = out_first;
  assign frame_stream.last_of_frame  = out_last;

`ifndef SYNTHESIS
  // no byte is taken while header bytes are still queued
  a_no_accept_during_hdr: assert property (@(posedge clk) disable iff (rst)
    rx_acc |-> hdr_left == 2'd0)
    else $error("byte accepted while header queued");

  // queued header bytes always sit behind a valid output
  a_hdr_implies_valid: assert property (@(posedge clk) disable iff (rst)
    hdr_left != 2'd0 |-> out_valid)
    else $error("header queued with empty output");

  // a frame start always carries the first sync byte
  a_first_is_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_first |-> out_byte == slfe_pkg::SYNC_FIRST && hdr_left == 2'd3)
    else $error("frame start without sync byte");
`endif

endmodule

// ===== rtl/core/slfe_parser.sv =====
// ----------------------------------------------------------------------------
// slfe_parser
// Sync hunt and length check. Advances once per accepted byte and reports
// whether the byte opens a frame (header) or passes through as payload.
// ----------------------------------------------------------------------------
module slfe_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          max_len,
  output slfe_pkg::parse_ev_t  ev
);

  slfe_pkg::phase_t phase;
  slfe_pkg::phase_t phase_next;
  logic [7:0]       len_lo;
  logic [15:0]      remaining;

  logic [15:0] len;
  logic        len_ok;
  logic [15:0] rem_hdr;
  logic [15:0] rem_dec;

  // Length decode and remaining-count arithmetic
  assign len     = {rx_byte, len_lo};
  assign len_ok  = (len >= slfe_pkg::MIN_LEN) && (len <= max_len);
  assign rem_hdr = len - slfe_pkg::MIN_LEN;
  assign rem_dec = (remaining == 16'd0) ? 16'd0 : remaining - 16'd1;

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      slfe_pkg::PH_SEEN_A5: begin
        if (rx_byte == slfe_pkg::SYNC_SECOND) begin
          phase_next = slfe_pkg::PH_LEN_LO;
        end else if (rx_byte != slfe_pkg::SYNC_FIRST) begin
          phase_next = slfe_pkg::PH_HUNT;
        end
      end
      slfe_pkg::PH_LEN_LO: begin
        phase_next = slfe_pkg::PH_LEN_HI;
      end
      slfe_pkg::PH_LEN_HI: begin
        if (!len_ok) begin
          // bad length: rescan the two length bytes for a sync pair
          if (len_lo == slfe_pkg::SYNC_FIRST && rx_byte == slfe_pkg::SYNC_SECOND) begin
            phase_next = slfe_pkg::PH_LEN_LO;
          end else if (rx_byte == slfe_pkg::SYNC_FIRST) begin
            phase_next = slfe_pkg::PH_SEEN_A5;
          end else begin
            phase_next = slfe_pkg::PH_HUNT;
          end
        end else if (rem_hdr == 16'd0) begin
          phase_next = slfe_pkg::PH_HUNT;
        end else begin
          phase_next = slfe_pkg::PH_PAYLOAD;
        end
      end
      slfe_pkg::PH_PAYLOAD: begin
        if (rem_dec == 16'd0) begin
          phase_next = slfe_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_next = (rx_byte == slfe_pkg::SYNC_FIRST) ? slfe_pkg::PH_SEEN_A5
                                                       : slfe_pkg::PH_HUNT;
      end
    endcase
  end

  // Event outputs
  always_comb begin
    ev = '0;
    case (phase)
      slfe_pkg::PH_LEN_HI: begin
        ev.emit_hdr = len_ok;
        ev.data     = len_lo;
        ev.len_hi   = rx_byte;
        ev.last     = (rem_hdr == 16'd0);
      end
      slfe_pkg::PH_PAYLOAD: begin
        ev.emit_byte = 1'b1;
        ev.data      = rx_byte;
        ev.last      = (rem_dec == 16'd0);
      end
      default: begin
        ev = '0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= slfe_pkg::PH_HUNT;
      len_lo    <= 8'd0;
      remaining <= 16'd0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == slfe_pkg::PH_LEN_LO) begin
        len_lo <= rx_byte;
      end
      if (phase == slfe_pkg::PH_LEN_HI && len_ok) begin
        remaining <= rem_hdr;
      end else if (phase == slfe_pkg::PH_PAYLOAD) begin
        remaining <= rem_dec;
      end
    end
  end

endmodule
